// ----- rtl/vmd_pkg.sv -----
// Shared constants, payload types and latencies for the view matrix block.
package vmd_pkg;

    localparam int DIR_W    = 16;            // direction component width
    localparam int POS_W    = 32;            // position / translation width
    localparam int DFB      = 14;            // direction fraction bits

    localparam int VEC_W    = 32;            // normalizer input component width
    localparam int MAG_W    = 30;            // magnitude width after scaling
    localparam int SH_N     = 5;             // left shift steps 16, 8, 4, 2, 1
    localparam int SQ_STEPS = 31;            // square root steps (two sum bits each)
    localparam int QW       = DFB + 1;       // quotient width
    localparam int REM_W    = MAG_W + DFB + 1;

    localparam int NRM_LAT  = 2 + SH_N + 2 + SQ_STEPS + 1 + QW + 1;
    localparam int XP_LAT   = 2;
    localparam int DOT_LAT  = 3;
    localparam int BACK_LAT = NRM_LAT + XP_LAT + NRM_LAT + DOT_LAT;

    localparam int QDEPTH   = 4;
    localparam int QAW      = $clog2(QDEPTH);

    typedef struct packed {
        logic signed [DIR_W-1:0] look_x;
        logic signed [DIR_W-1:0] look_y;
        logic signed [DIR_W-1:0] look_z;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
    } t_in_item;

    typedef struct packed {
        logic signed [DIR_W-1:0] right_x;
        logic signed [DIR_W-1:0] right_y;
        logic signed [DIR_W-1:0] right_z;
        logic signed [DIR_W-1:0] up_x;
        logic signed [DIR_W-1:0] up_y;
        logic signed [DIR_W-1:0] up_z;
        logic signed [POS_W-1:0] trans_x;
        logic signed [POS_W-1:0] trans_y;
        logic signed [POS_W-1:0] trans_z;
        logic                    degenerate;
    } t_out_item;

    // queue entry: item plus the classification done up front
    typedef struct packed {
        t_in_item item;
        logic     degen;
    } t_qent;

endpackage

// ----- rtl/vmd_front.sv -----
// Input stage: registers an item, flags a look direction parallel to Y.
module vmd_front import vmd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_data,
    output logic     o_push,
    output t_qent    o_ent,
    input  logic     i_full
);

    logic  r_vld, n_vld;
    t_qent r_ent;
    logic  acc;

    assign o_push     = r_vld && !i_full;
    assign o_in_ready = !r_vld || !i_full;
    assign acc        = i_in_valid && o_in_ready;
    assign o_ent      = r_ent;

    always_comb begin
        n_vld = r_vld;
        if (o_push) n_vld = 1'b0;
        if (acc)    n_vld = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
        if (acc) begin
            r_ent.item  <= i_in_data;
            r_ent.degen <= (i_in_data.look_x == '0) && (i_in_data.look_z == '0);
        end
    end

endmodule

// ----- rtl/vmd_queue.sv -----
// Short FIFO between the front stage and the arithmetic pipeline.
module vmd_queue import vmd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_qent i_data,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_qent o_data
);

    t_qent          r_mem [QDEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QAW:0]   r_cnt;

    assign o_full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
        if (i_push) r_mem[r_wp] <= i_data;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_cnt != '0) else $error("pop from empty queue");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (QAW+1)'(QDEPTH)) else $error("queue count out of range");

endmodule

// ----- rtl/vmd_norm.sv -----
// Pipelined 3-vector normalizer: scale, sum of squares, square root, divide.
module vmd_norm import vmd_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [2:0][VEC_W-1:0]  i_vec,
    output logic [2:0][DIR_W-1:0]  o_dir
);

    typedef struct packed {
        logic                  zero;
        logic [2:0]            neg;
        logic [2:0][MAG_W-1:0] m;
    } t_side;

    logic [2:0][MAG_W:0]     r_m1, n_m1;
    logic [2:0]              r_neg1, n_neg1;
    t_side                   r_sh [SH_N+1];
    t_side                   n_sh [SH_N+1];
    logic [2:0][2*MAG_W-1:0] r_sq, n_sq;
    t_side                   r_sqs;
    logic [63:0]             r_v [SQ_STEPS+1];
    logic [63:0]             n_v [SQ_STEPS+1];
    logic [63:0]             r_r [SQ_STEPS+1];
    logic [63:0]             n_r [SQ_STEPS+1];
    t_side                   r_is [SQ_STEPS+1];
    logic [2:0][REM_W-1:0]   r_rem [QW+1];
    logic [2:0][REM_W-1:0]   n_rem [QW+1];
    logic [2:0][QW-1:0]      r_q [QW+1];
    logic [2:0][QW-1:0]      n_q [QW+1];
    logic [MAG_W:0]          r_n [QW+1];
    logic [MAG_W:0]          n_n [QW+1];
    logic [2:0]              r_dneg [QW+1];
    logic                    r_dz [QW+1];
    logic [2:0][DIR_W-1:0]   r_out, n_out;

    assign o_dir = r_out;

    // magnitudes and signs
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_neg1[i] = i_vec[i][VEC_W-1];
            n_m1[i]   = n_neg1[i] ? (MAG_W+1)'(-i_vec[i]) : i_vec[i][MAG_W:0];
        end
    end

    // bring the largest magnitude into [2^29, 2^30)
    always_comb begin
        logic [MAG_W:0]   or1;
        logic [MAG_W-1:0] orv;
        int               amt;
        or1 = r_m1[0] | r_m1[1] | r_m1[2];
        n_sh[0].zero = (or1 == '0);
        n_sh[0].neg  = r_neg1;
        for (int i = 0; i < 3; i++) begin
            n_sh[0].m[i] = or1[MAG_W] ? r_m1[i][MAG_W:1] : r_m1[i][MAG_W-1:0];
        end
        for (int j = 0; j < SH_N; j++) begin
            amt = 1 << (SH_N - 1 - j);
            n_sh[j+1] = r_sh[j];
            orv = r_sh[j].m[0] | r_sh[j].m[1] | r_sh[j].m[2];
            if ((orv >> (MAG_W - amt)) == '0) begin
                for (int i = 0; i < 3; i++) n_sh[j+1].m[i] = r_sh[j].m[i] << amt;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_sq[i] = (2*MAG_W)'(r_sh[SH_N].m[i]) * (2*MAG_W)'(r_sh[SH_N].m[i]);
        end
    end

    // sum of squares, then integer square root two bits a stage
    always_comb begin
        logic [63:0] bitv;
        logic [63:0] t;
        n_v[0] = 64'(r_sq[0]) + 64'(r_sq[1]) + 64'(r_sq[2]);
        n_r[0] = '0;
        for (int j = 0; j < SQ_STEPS; j++) begin
            bitv = 64'(1) << (2 * (SQ_STEPS - 1 - j));
            t    = r_r[j] + bitv;
            if (r_v[j] >= t) begin
                n_v[j+1] = r_v[j] - t;
                n_r[j+1] = (r_r[j] >> 1) + bitv;
            end else begin
                n_v[j+1] = r_v[j];
                n_r[j+1] = r_r[j] >> 1;
            end
        end
    end

    // rounded restoring division, one quotient bit a stage
    always_comb begin
        logic [REM_W-1:0] d;
        n_n[0] = r_r[SQ_STEPS][MAG_W:0];
        for (int i = 0; i < 3; i++) begin
            n_rem[0][i] = (REM_W'(r_is[SQ_STEPS].m[i]) << DFB) + REM_W'(n_n[0] >> 1);
        end
        n_q[0] = '0;
        for (int j = 0; j < QW; j++) begin
            d          = REM_W'(r_n[j]) << (QW - 1 - j);
            n_n[j+1]   = r_n[j];
            n_rem[j+1] = r_rem[j];
            n_q[j+1]   = r_q[j];
            for (int i = 0; i < 3; i++) begin
                if (r_rem[j][i] >= d) begin
                    n_rem[j+1][i]          = r_rem[j][i] - d;
                    n_q[j+1][i][QW-1-j]    = 1'b1;
                end
            end
        end
    end

    always_comb begin
        logic [QW-1:0] q;
        for (int i = 0; i < 3; i++) begin
            q = r_q[QW][i];
            if (q > QW'(1 << DFB)) q = QW'(1 << DFB);
            if (r_dz[QW])          n_out[i] = '0;
            else if (r_dneg[QW][i]) n_out[i] = -DIR_W'(q);
            else                   n_out[i] = DIR_W'(q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m1   <= n_m1;
            r_neg1 <= n_neg1;
            for (int j = 0; j <= SH_N; j++) r_sh[j] <= n_sh[j];
            r_sq  <= n_sq;
            r_sqs <= r_sh[SH_N];
            r_is[0] <= r_sqs;
            for (int j = 0; j <= SQ_STEPS; j++) begin
                r_v[j] <= n_v[j];
                r_r[j] <= n_r[j];
            end
            for (int j = 1; j <= SQ_STEPS; j++) r_is[j] <= r_is[j-1];
            r_dneg[0] <= r_is[SQ_STEPS].neg;
            r_dz[0]   <= r_is[SQ_STEPS].zero;
            for (int j = 0; j <= QW; j++) begin
                r_rem[j] <= n_rem[j];
                r_q[j]   <= n_q[j];
                r_n[j]   <= n_n[j];
            end
            for (int j = 1; j <= QW; j++) begin
                r_dneg[j] <= r_dneg[j-1];
                r_dz[j]   <= r_dz[j-1];
            end
            r_out <= n_out;
        end
    end

endmodule

// ----- rtl/vmd_dot.sv -----
// Pipelined negated dot product with rounding and saturation to the position format.
module vmd_dot import vmd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [2:0][DIR_W-1:0] i_dir,
    input  logic [2:0][POS_W-1:0] i_pos,
    output logic [POS_W-1:0]      o_trans
);

    localparam int PW = DIR_W + POS_W;
    localparam int AW = PW + 4;
    localparam int SW = AW - DFB;
    localparam logic signed [SW-1:0] SMAX = SW'($signed({1'b0, {(POS_W-1){1'b1}}}));
    localparam logic signed [SW-1:0] SMIN = SW'($signed({1'b1, {(POS_W-1){1'b0}}}));

    logic [2:0][PW-1:0]     r_prod, n_prod;
    logic signed [AW-1:0]   r_acc, n_acc;
    logic [POS_W-1:0]       r_out, n_out;

    assign o_trans = r_out;

    always_comb begin
        logic signed [PW-1:0] a;
        logic signed [PW-1:0] b;
        for (int i = 0; i < 3; i++) begin
            a         = PW'($signed(i_dir[i]));
            b         = PW'($signed(i_pos[i]));
            n_prod[i] = a * b;
        end
    end

    always_comb begin
        logic signed [AW-1:0] s;
        s = AW'($signed(r_prod[0])) + AW'($signed(r_prod[1])) + AW'($signed(r_prod[2]));
        n_acc = AW'(1 << (DFB - 1)) - s;
    end

    always_comb begin
        logic signed [AW-1:0] shw;
        logic signed [SW-1:0] sh;
        shw = r_acc >>> DFB;
        sh  = shw[SW-1:0];
        if (sh > SMAX)      n_out = SMAX[POS_W-1:0];
        else if (sh < SMIN) n_out = SMIN[POS_W-1:0];
        else                n_out = sh[POS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
            r_acc  <= n_acc;
            r_out  <= n_out;
        end
    end

endmodule

// ----- rtl/vmd_back.sv -----
// Arithmetic pipeline: right vector, up vector from the cross product, translation.
module vmd_back import vmd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_vld,
    input  t_qent     i_q_ent,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    typedef struct packed {
        t_qent                 ent;
        logic [2:0][DIR_W-1:0] rgt;
    } t_carry_b;

    typedef struct packed {
        logic                  degen;
        logic [2:0][DIR_W-1:0] rgt;
        logic [2:0][DIR_W-1:0] up;
    } t_carry_c;

    logic                  en;
    logic [BACK_LAT-1:0]   r_vld;
    logic [2:0][VEC_W-1:0] w_rv;
    logic [2:0][DIR_W-1:0] w_rgt, w_up;
    t_qent                 r_da [NRM_LAT];
    logic [3:0][VEC_W-1:0] r_x1_p, n_x1_p;
    t_carry_b              r_x1_b, r_x2_b;
    logic [2:0][VEC_W-1:0] r_uv, n_uv;
    t_carry_b              r_db [NRM_LAT];
    t_carry_c              r_dc [DOT_LAT];
    t_carry_b              lb;
    t_in_item              la;
    logic [2:0][DIR_W-1:0] w_look;
    logic [2:0][POS_W-1:0] w_pos;
    logic [POS_W-1:0]      w_tx, w_ty, w_tz;

    // whole pipeline advances together; the last stage is the output register
    assign en          = !r_vld[BACK_LAT-1] || i_out_ready;
    assign o_pop       = en && i_q_vld;
    assign o_out_valid = r_vld[BACK_LAT-1];

    // Y x look = (look_z, 0, -look_x)
    always_comb begin
        w_rv[0] = VEC_W'($signed(i_q_ent.item.look_z));
        w_rv[1] = '0;
        w_rv[2] = -VEC_W'($signed(i_q_ent.item.look_x));
    end

    vmd_norm u_norm_rgt (
        .i_clk (i_clk),
        .i_en  (en),
        .i_vec (w_rv),
        .o_dir (w_rgt)
    );

    // look x right with right_y zero
    always_comb begin
        logic signed [VEC_W-1:0] l0, l1, l2, r0, r2;
        la = r_da[NRM_LAT-1].item;
        l0 = VEC_W'($signed(la.look_x));
        l1 = VEC_W'($signed(la.look_y));
        l2 = VEC_W'($signed(la.look_z));
        r0 = VEC_W'($signed(w_rgt[0]));
        r2 = VEC_W'($signed(w_rgt[2]));
        n_x1_p[0] = l1 * r2;
        n_x1_p[1] = l2 * r0;
        n_x1_p[2] = l0 * r2;
        n_x1_p[3] = l1 * r0;
    end

    always_comb begin
        n_uv[0] = r_x1_p[0];
        n_uv[1] = r_x1_p[1] - r_x1_p[2];
        n_uv[2] = -r_x1_p[3];
    end

    vmd_norm u_norm_up (
        .i_clk (i_clk),
        .i_en  (en),
        .i_vec (r_uv),
        .o_dir (w_up)
    );

    always_comb begin
        lb        = r_db[NRM_LAT-1];
        w_look[0] = lb.ent.item.look_x;
        w_look[1] = lb.ent.item.look_y;
        w_look[2] = lb.ent.item.look_z;
        w_pos[0]  = lb.ent.item.pos_x;
        w_pos[1]  = lb.ent.item.pos_y;
        w_pos[2]  = lb.ent.item.pos_z;
    end

    vmd_dot u_dot_x (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_dir   (lb.rgt),
        .i_pos   (w_pos),
        .o_trans (w_tx)
    );

    vmd_dot u_dot_y (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_dir   (w_up),
        .i_pos   (w_pos),
        .o_trans (w_ty)
    );

    vmd_dot u_dot_z (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_dir   (w_look),
        .i_pos   (w_pos),
        .o_trans (w_tz)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[BACK_LAT-2:0], i_q_vld};
        end
        if (en) begin
            r_da[0] <= i_q_ent;
            for (int k = 1; k < NRM_LAT; k++) r_da[k] <= r_da[k-1];
            r_x1_p     <= n_x1_p;
            r_x1_b.ent <= r_da[NRM_LAT-1];
            r_x1_b.rgt <= w_rgt;
            r_uv       <= n_uv;
            r_x2_b     <= r_x1_b;
            r_db[0]    <= r_x2_b;
            for (int k = 1; k < NRM_LAT; k++) r_db[k] <= r_db[k-1];
            r_dc[0].degen <= lb.ent.degen;
            r_dc[0].rgt   <= lb.rgt;
            r_dc[0].up    <= w_up;
            for (int k = 1; k < DOT_LAT; k++) r_dc[k] <= r_dc[k-1];
        end
    end

    always_comb begin
        o_out_data.right_x    = r_dc[DOT_LAT-1].rgt[0];
        o_out_data.right_y    = r_dc[DOT_LAT-1].rgt[1];
        o_out_data.right_z    = r_dc[DOT_LAT-1].rgt[2];
        o_out_data.up_x       = r_dc[DOT_LAT-1].up[0];
        o_out_data.up_y       = r_dc[DOT_LAT-1].up[1];
        o_out_data.up_z       = r_dc[DOT_LAT-1].up[2];
        o_out_data.trans_x    = w_tx;
        o_out_data.trans_y    = w_ty;
        o_out_data.trans_z    = w_tz;
        o_out_data.degenerate = r_dc[DOT_LAT-1].degen;
    end

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.degenerate |->
            o_out_data.right_x == '0 && o_out_data.right_z == '0 &&
            o_out_data.up_x == '0 && o_out_data.up_y == '0 && o_out_data.up_z == '0 &&
            o_out_data.trans_x == '0 && o_out_data.trans_y == '0)
        else $error("degenerate item with nonzero basis");
    a_right_y_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.right_y == '0) else $error("right_y not zero");
    a_pop_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_vld[0]) else $error("popped item lost from pipeline");

endmodule

// ----- rtl/view_matrix_from_direction_top.sv -----
// Top level of the look-at view basis block.
//
//   channel | direction | handshake                | payload
//   input   | in        | i_in_valid / o_in_ready   | i_in_data  (t_in_item)
//   output  | out       | o_out_valid / i_out_ready | o_out_data (t_out_item)
//
// One item per cycle sustained while the output is accepted (i_out_ready high).
// Latency is set by the two 57-stage normalizers (31-step square root, 15-step divider).
// A 4-entry queue separates the input register from the arithmetic pipeline.
// The pipeline freezes as a whole while the output item waits; the queue keeps input flowing until it fills.
// Reset (i_rst_n, synchronous) clears valid flags, queue pointers and the queue count only.
module view_matrix_from_direction_top import vmd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    logic  push, full, pop, q_vld;
    t_qent f_ent, q_ent;

    vmd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_push     (push),
        .o_ent      (f_ent),
        .i_full     (full)
    );

    vmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (f_ent),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_vld),
        .o_data  (q_ent)
    );

    vmd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_vld     (q_vld),
        .i_q_ent     (q_ent),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
